FILE: src/vdq_pkg.sv
// ----------------------------------------------------------------------------
// vdq_pkg
// Shared constants, types and helper functions of the vector
// direction quantizer: datapath widths and the cordic step angle table.
// ----------------------------------------------------------------------------
package vdq_pkg;

  localparam int ANGLE_COUNT_DEF = 64;
  localparam int COORD_WIDTH_DEF = 16;

  localparam int FRAC_BITS    = 48;
  localparam int CORDIC_STEPS = 50;
  localparam int NORM_BIT     = 58;
  localparam int XW           = 64;
  localparam int ZW           = FRAC_BITS + 3;
  localparam int POS_W        = FRAC_BITS + 3;
  localparam int SHW          = $clog2(NORM_BIT + 1);
  localparam int DIR_W        = 6;

  typedef struct packed {
    logic [2:0] oct;
    logic       bzero;
  } side_t;

  // restoring division, used only while elaborating constants
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], n[k]};
      if (r >= d) begin
        r = r - d;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/m) in q62 radians, truncated series
  function automatic logic [63:0] atan_recip(input logic [63:0] m);
    logic [63:0] p;
    logic [63:0] acc;
    logic [63:0] t;
    p   = udiv64(64'h4000_0000_0000_0000, m);
    acc = '0;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        t = udiv64(p, 64'(2 * k + 1));
        if (k[0]) acc = acc - t;
        else      acc = acc + t;
        p = udiv64(udiv64(p, m), m);
      end
    end
    return acc;
  endfunction

  // floor(num * 2^FRAC_BITS / den)
  function automatic logic [63:0] frac_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = num;
    for (int k = 0; k < FRAC_BITS; k++) begin
      r = {r[62:0], 1'b0};
      q = {q[62:0], 1'b0};
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // step angle in units of pi/4
  function automatic logic [63:0] step_angle(input int idx);
    logic [63:0] quarter;
    quarter = atan_recip(64'd2) + atan_recip(64'd3);
    if (idx == 0) return 64'd1 << FRAC_BITS;
    return frac_div(atan_recip(64'd1 << idx), quarter);
  endfunction

  // arithmetic shift right rounding toward zero
  function automatic logic signed [XW-1:0] shr_tz(input logic signed [XW-1:0] v,
                                                  input int s);
    logic signed [XW-1:0] fl;
    logic [XW-1:0]        mask;
    fl   = v >>> s;
    mask = ~({XW{1'b1}} << s);
    if (v[XW-1] && ((v & mask) != '0)) fl = fl + XW'(1);
    return fl;
  endfunction

endpackage

FILE: src/vdq_octant.sv
// ----------------------------------------------------------------------------
// vdq_octant
// Exact octant reduction: negates the vector, picks the octant by integer
// compares and forms the in-octant pair (a, b) with 0 <= b < a.
// ----------------------------------------------------------------------------
module vdq_octant import vdq_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int AW          = COORD_WIDTH + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] vec_y,
  input  logic signed [COORD_WIDTH-1:0] vec_x,
  output logic                          out_valid,
  output logic [AW-1:0]                 a,
  output logic [AW-1:0]                 b,
  output side_t                         side
);

  logic signed [AW-1:0] xe;
  logic signed [AW-1:0] ye;
  logic signed [AW-1:0] xn;
  logic signed [AW-1:0] yn;
  logic signed [AW-1:0] pp;
  logic signed [AW-1:0] qq;
  logic [AW-1:0]        pu;
  logic [AW-1:0]        qu;
  logic [2:0]           quad;
  logic [AW-1:0]        a_next;
  logic [AW-1:0]        b_next;
  side_t                side_next;

  always_comb begin
    xe = {vec_x[COORD_WIDTH-1], vec_x};
    ye = {vec_y[COORD_WIDTH-1], vec_y};
    xn = -xe;
    yn = -ye;
    if (xn == '0 && yn == '0) xn = '1;
    if (xn > 0 && yn >= 0) begin
      quad = 3'd0; pp = xn; qq = yn;
    end else if (xn <= 0 && yn > 0) begin
      quad = 3'd2; pp = yn; qq = -xn;
    end else if (xn < 0 && yn <= 0) begin
      quad = 3'd4; pp = -xn; qq = -yn;
    end else begin
      quad = 3'd6; pp = -yn; qq = xn;
    end
    pu = pp;
    qu = qq;
    if (qu < pu) begin
      a_next        = pu;
      b_next        = qu;
      side_next.oct = quad;
    end else begin
      a_next        = pu + qu;
      b_next        = qu - pu;
      side_next.oct = quad + 3'd1;
    end
    side_next.bzero = (b_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a    <= a_next;
    b    <= b_next;
    side <= side_next;
  end

endmodule

FILE: src/vdq_norm.sv
// ----------------------------------------------------------------------------
// vdq_norm
// Normalizer: finds the leading one of a, then shifts a and b left so that
// a lands in [2^58, 2^59); two register stages.
// ----------------------------------------------------------------------------
module vdq_norm import vdq_pkg::*; #(
  parameter int AW = COORD_WIDTH_DEF + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [AW-1:0]        a,
  input  logic [AW-1:0]        b,
  input  side_t                in_side,
  output logic                 out_valid,
  output logic signed [XW-1:0] x,
  output logic signed [XW-1:0] y,
  output side_t                out_side
);

  logic [SHW-1:0] sh_next;
  logic [SHW-1:0] sh;
  logic [AW-1:0]  a_r;
  logic [AW-1:0]  b_r;
  side_t          side_r;
  logic           valid_r;

  always_comb begin
    sh_next = SHW'(NORM_BIT);
    for (int k = 0; k < AW; k++) begin
      if (a[k]) sh_next = SHW'(NORM_BIT - k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid_r   <= in_valid;
      out_valid <= valid_r;
    end
  end

  always_ff @(posedge clk) begin
    sh       <= sh_next;
    a_r      <= a;
    b_r      <= b;
    side_r   <= in_side;
    x        <= XW'(a_r) << sh;
    y        <= XW'(b_r) << sh;
    out_side <= side_r;
  end

endmodule

FILE: src/vdq_cordic_stage.sv
// ----------------------------------------------------------------------------
// vdq_cordic_stage
// One vectoring-mode cordic iteration with a fixed shift and step angle,
// registered.
// ----------------------------------------------------------------------------
module vdq_cordic_stage import vdq_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [XW-1:0] in_y,
  input  logic signed [ZW-1:0] in_z,
  input  side_t                in_side,
  output logic                 out_valid,
  output logic signed [XW-1:0] out_x,
  output logic signed [XW-1:0] out_y,
  output logic signed [ZW-1:0] out_z,
  output side_t                out_side
);

  localparam logic [63:0]          STEP_RAW = step_angle(STAGE);
  localparam logic signed [ZW-1:0] STEP     = STEP_RAW[ZW-1:0];

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;
  logic signed [ZW-1:0] z_next;

  always_comb begin
    dx = shr_tz(in_y, STAGE);
    dy = shr_tz(in_x, STAGE);
    if (!in_y[XW-1]) begin
      x_next = in_x + dx;
      y_next = in_y - dy;
      z_next = in_z + STEP;
    end else begin
      x_next = in_x - dx;
      y_next = in_y + dy;
      z_next = in_z - STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_x    <= x_next;
    out_y    <= y_next;
    out_z    <= z_next;
    out_side <= in_side;
  end

endmodule

FILE: src/vdq_sector.sv
// ----------------------------------------------------------------------------
// vdq_sector
// Sector mapping: clamps the residual angle, scales octant position to
// sectors and rotates by three quarters of a turn; three register stages.
// ----------------------------------------------------------------------------
module vdq_sector import vdq_pkg::*; #(
  parameter int ANGLE_COUNT = ANGLE_COUNT_DEF,
  parameter int RW          = $clog2(ANGLE_COUNT),
  parameter int NW          = $clog2(ANGLE_COUNT + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [ZW-1:0] z,
  input  side_t                side,
  output logic                 done,
  output logic [DIR_W-1:0]     direction_index
);

  localparam int ROT_OFS = (3 * ANGLE_COUNT) / 4;

  logic [FRAC_BITS-1:0]  u_next;
  logic [FRAC_BITS-1:0]  u;
  logic [2:0]            oct;
  logic                  u_valid;
  logic [POS_W+NW-1:0]   prod;
  logic [RW-1:0]         rot;
  logic                  rot_valid;
  logic [RW:0]           sum;
  logic [RW-1:0]         dir_next;
  logic [RW+DIR_W-1:0]   dir_ext;

  always_comb begin
    if (side.bzero || z[ZW-1]) begin
      u_next = '0;
    end else if (|z[ZW-2:FRAC_BITS]) begin
      u_next = '1;
    end else begin
      u_next = z[FRAC_BITS-1:0];
    end
  end

  assign prod = POS_W'({oct, u}) * NW'(ANGLE_COUNT);

  always_comb begin
    sum = {1'b0, rot} + (RW + 1)'(ROT_OFS);
    if (sum >= (RW + 1)'(ANGLE_COUNT)) sum = sum - (RW + 1)'(ANGLE_COUNT);
    dir_next = sum[RW-1:0];
    dir_ext  = (RW + DIR_W)'(dir_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u_valid   <= 1'b0;
      rot_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      u_valid   <= in_valid;
      rot_valid <= u_valid;
      done      <= rot_valid;
    end
  end

  always_ff @(posedge clk) begin
    u               <= u_next;
    oct             <= side.oct;
    rot             <= prod[POS_W +: RW];
    direction_index <= dir_ext[DIR_W-1:0];
  end

endmodule

FILE: src/vector_direction_quantizer_unit.sv
// ----------------------------------------------------------------------------
// vector_direction_quantizer_unit
// Quantizes the direction of a signed 2-d vector into ANGLE_COUNT sectors,
// heading 0 straight up, using exact octant reduction and a 50-step cordic.
// Pipeline: 3 reduction stages, one cordic stage per iteration and 3 sector
// stages, with done raised by the last sector stage.
// Throughput: one item per cycle; busy never rises since nothing stalls.
// Reset clears every valid bit; no item in flight survives it.
// ----------------------------------------------------------------------------
module vector_direction_quantizer_unit import vdq_pkg::*; #(
  parameter int ANGLE_COUNT = ANGLE_COUNT_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] vec_y,
  input  logic signed [COORD_WIDTH-1:0] vec_x,
  output logic                          done,
  output logic [DIR_W-1:0]              direction_index
);

  localparam int AW = COORD_WIDTH + 1;

  logic                 oct_valid;
  logic [AW-1:0]        oct_a;
  logic [AW-1:0]        oct_b;
  side_t                oct_side;

  logic                 st_valid [CORDIC_STEPS+1];
  logic signed [XW-1:0] st_x     [CORDIC_STEPS+1];
  logic signed [XW-1:0] st_y     [CORDIC_STEPS+1];
  logic signed [ZW-1:0] st_z     [CORDIC_STEPS+1];
  side_t                st_side  [CORDIC_STEPS+1];

  assign busy = 1'b0;

  vdq_octant #(
    .COORD_WIDTH(COORD_WIDTH),
    .AW         (AW)
  ) u_octant (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start & ~busy),
    .vec_y    (vec_y),
    .vec_x    (vec_x),
    .out_valid(oct_valid),
    .a        (oct_a),
    .b        (oct_b),
    .side     (oct_side)
  );

  vdq_norm #(
    .AW(AW)
  ) u_norm (
    .clk      (clk),
    .rst      (rst),
    .in_valid (oct_valid),
    .a        (oct_a),
    .b        (oct_b),
    .in_side  (oct_side),
    .out_valid(st_valid[0]),
    .x        (st_x[0]),
    .y        (st_y[0]),
    .out_side (st_side[0])
  );

  assign st_z[0] = '0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    vdq_cordic_stage #(
      .STAGE(i)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (st_valid[i]),
      .in_x     (st_x[i]),
      .in_y     (st_y[i]),
      .in_z     (st_z[i]),
      .in_side  (st_side[i]),
      .out_valid(st_valid[i+1]),
      .out_x    (st_x[i+1]),
      .out_y    (st_y[i+1]),
      .out_z    (st_z[i+1]),
      .out_side (st_side[i+1])
    );
  end

  vdq_sector #(
    .ANGLE_COUNT(ANGLE_COUNT)
  ) u_sector (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (st_valid[CORDIC_STEPS]),
    .z              (st_z[CORDIC_STEPS]),
    .side           (st_side[CORDIC_STEPS]),
    .done           (done),
    .direction_index(direction_index)
  );

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// vector direction quantizer testbench
// Sends signed 2-d vectors through the command handshake and checks each
// quantized heading against an in-bench predictor. The predictor does an
// exact octant split and then a fixed-point cordic on the residual angle.
// Directed items cover the origin, the axes, the octant diagonals and the
// coordinate extremes. Random items cover full-range, small, near-diagonal,
// near-axis and rescaled vectors. Sender gaps are random, with one run of
// back-to-back items and one full drain.
module testbench import vdq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SECTORS        = 64;
  localparam int COORD_W        = 16;
  localparam int FRAC_W         = 48;
  localparam int ARC_STEPS      = 50;
  localparam int NORM_SHIFT     = 58;
  localparam int DRAIN_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam longint UNIT_ANGLE = longint'(1) << FRAC_W;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [COORD_W-1:0] vec_y = '0;
  logic signed [COORD_W-1:0] vec_x = '0;
  logic                      done;
  logic [DIR_W-1:0]          direction_index;

  longint unsigned  arc_step [ARC_STEPS];
  logic [DIR_W-1:0] heading_q [$];
  logic [DIR_W-1:0] expected_heading;
  logic [SECTORS-1:0] sector_seen = '0;
  int               n_sent = 0;
  int               n_checked = 0;
  int               n_errors = 0;
  int               stall_cycles = 0;

  vector_direction_quantizer_unit #(
    .ANGLE_COUNT(SECTORS),
    .COORD_WIDTH(COORD_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .vec_y(vec_y),
    .vec_x(vec_x),
    .done(done),
    .direction_index(direction_index)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // atan(1/m) in q62 radians by a truncated series
  function automatic longint unsigned atan_inv(input longint unsigned m);
    longint unsigned p;
    longint unsigned acc;
    longint unsigned t;
    longint unsigned k;
    p = (64'd1 << 62) / m;
    acc = 0;
    k = 0;
    while (p != 0) begin
      t = p / (2 * k + 1);
      if (k % 2 == 1) acc = acc - t;
      else acc = acc + t;
      p = p / m / m;
      k = k + 1;
    end
    return acc;
  endfunction

  // floor(num * 2^FRAC_W / den)
  function automatic longint unsigned scaled_quotient(input longint unsigned num,
                                                      input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = num;
    for (int i = 0; i < FRAC_W; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic void build_arc_table();
    longint unsigned quarter_turn;
    quarter_turn = atan_inv(2) + atan_inv(3);
    arc_step[0] = 64'd1 << FRAC_W;
    for (int i = 1; i < ARC_STEPS; i++)
      arc_step[i] = scaled_quotient(atan_inv(64'd1 << i), quarter_turn);
  endfunction

  function automatic longint shift_tz(input longint v, input int s);
    longint unsigned mag;
    if (v < 0) begin
      mag = -v;
      return -longint'(mag >> s);
    end
    mag = v;
    return longint'(mag >> s);
  endfunction

  // angle of (a, b) inside an octant, in units of pi/4
  function automatic longint unsigned octant_residual(input longint unsigned a,
                                                      input longint unsigned b);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    if (b == 0) return 0;
    while (a < (64'd1 << NORM_SHIFT)) begin
      a = a << 1;
      b = b << 1;
    end
    x = a;
    y = b;
    z = 0;
    for (int i = 0; i < ARC_STEPS; i++) begin
      dx = shift_tz(y, i);
      dy = shift_tz(x, i);
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(arc_step[i]);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(arc_step[i]);
      end
    end
    if (z < 0) return 0;
    if (z >= UNIT_ANGLE) return UNIT_ANGLE - 1;
    return z;
  endfunction

  function automatic logic [DIR_W-1:0] predict_heading(input logic signed [COORD_W-1:0] vy,
                                                       input logic signed [COORD_W-1:0] vx);
    longint          px;
    longint          py;
    longint          p;
    longint          q;
    longint unsigned a;
    longint unsigned b;
    longint unsigned pos;
    longint unsigned sector;
    int              oct;
    // angle of the negated vector, zero vector taken as angle pi
    py = -longint'(vy);
    px = -longint'(vx);
    if (px == 0 && py == 0) px = -1;
    if (px > 0 && py >= 0) begin
      oct = 0; p = px; q = py;
    end else if (px <= 0 && py > 0) begin
      oct = 2; p = py; q = -px;
    end else if (px < 0 && py <= 0) begin
      oct = 4; p = -px; q = -py;
    end else begin
      oct = 6; p = -py; q = px;
    end
    if (q < p) begin
      a = p;
      b = q;
    end else begin
      oct = oct + 1;
      a = p + q;
      b = q - p;
    end
    pos = (64'(oct) << FRAC_W) + octant_residual(a, b);
    sector = (pos * SECTORS) >> (FRAC_W + 3);
    sector = (sector + (3 * SECTORS) / 4) % SECTORS;
    return sector[DIR_W-1:0];
  endfunction

  task automatic send_vector(input logic signed [COORD_W-1:0] vy,
                             input logic signed [COORD_W-1:0] vx);
    start <= 1'b1;
    vec_y <= vy;
    vec_x <= vx;
    @(posedge clk);
    while (busy) @(posedge clk);
    heading_q.push_back(predict_heading(vy, vx));
    n_sent++;
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      vec_y <= COORD_W'($urandom);
      vec_x <= COORD_W'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int random_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [COORD_W-1:0] signed_mag(input int mag);
    if ($urandom_range(0, 1)) return COORD_W'(-mag);
    return COORD_W'(mag);
  endfunction

  task automatic test_axes_and_origin();
    send_vector(0, 0);
    send_vector(0, 32767);
    send_vector(0, -32768);
    send_vector(0, 1);
    send_vector(0, -1);
    send_vector(32767, 0);
    send_vector(-32768, 0);
    send_vector(1, 0);
    send_vector(-1, 0);
    idle_cycles(random_gap());
  endtask

  task automatic test_octant_edges();
    send_vector(1, 1);
    send_vector(1, -1);
    send_vector(-1, 1);
    send_vector(-1, -1);
    send_vector(32767, 32767);
    send_vector(-32768, -32768);
    send_vector(-32768, 32767);
    send_vector(32767, -32768);
    send_vector(32767, 32766);
    send_vector(1, 32767);
    send_vector(-32768, -1);
    idle_cycles(random_gap());
  endtask

  task automatic test_random_headings(input int count);
    int                        k;
    int                        d;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] vx;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          vy = COORD_W'($urandom);
          vx = COORD_W'($urandom);
        end
        2: begin
          vy = COORD_W'($urandom_range(0, 8) - 4);
          vx = COORD_W'($urandom_range(0, 8) - 4);
        end
        3: begin
          // near a diagonal
          k = $urandom_range(1, 32000);
          d = $urandom_range(0, 16) - 8;
          vy = signed_mag(k);
          vx = signed_mag(k + d);
        end
        4: begin
          // near an axis
          vy = COORD_W'($urandom_range(0, 6) - 3);
          vx = COORD_W'($urandom);
          if ($urandom_range(0, 1)) begin
            vx = vy;
            vy = COORD_W'($urandom);
          end
        end
        default: begin
          vy = COORD_W'($urandom) >>> $urandom_range(0, 14);
          vx = COORD_W'($urandom) >>> $urandom_range(0, 14);
        end
      endcase
      send_vector(vy, vx);
      idle_cycles(random_gap());
    end
  endtask

  task automatic test_drain_pause();
    for (int n = 0; n < 30; n++) begin
      send_vector(COORD_W'($urandom), COORD_W'($urandom));
      idle_cycles(random_gap());
    end
    start <= 1'b0;
    while (heading_q.size() != 0) @(posedge clk);
    for (int n = 0; n < 30; n++)
      send_vector(COORD_W'($urandom), COORD_W'($urandom));
    idle_cycles(random_gap());
  endtask

  task automatic test_back_to_back();
    for (int n = 0; n < 200; n++) begin
      case ($urandom_range(0, 3))
        0: send_vector(signed_mag(32767), COORD_W'($urandom));
        1: send_vector(COORD_W'($urandom), -32768);
        default: send_vector(COORD_W'($urandom), COORD_W'($urandom));
      endcase
    end
    idle_cycles(1);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      n_checked++;
      sector_seen[direction_index] = 1'b1;
      if (heading_q.size() == 0) begin
        n_errors++;
        $error("direction_index: no item pending, actual %0d", direction_index);
      end else begin
        expected_heading = heading_q.pop_front();
        if (direction_index !== expected_heading) begin
          n_errors++;
          $error("direction_index: expected %0d, actual %0d",
                 expected_heading, direction_index);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    build_arc_table();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_axes_and_origin();
    test_octant_edges();
    test_random_headings(1360);
    test_drain_pause();
    test_back_to_back();
    start <= 1'b0;
    while (heading_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d vectors: origin, axes, diagonals, extremes, random mixes",
             n_sent);
    $display("checked %0d headings, %0d of %0d sectors seen",
             n_checked, $countones(sector_seen), SECTORS);
    if (n_errors == 0 && heading_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/vdq_pkg.sv
src/vdq_octant.sv
src/vdq_norm.sv
src/vdq_cordic_stage.sv
src/vdq_sector.sv
src/vector_direction_quantizer_unit.sv
tb/sv/testbench.sv
